/* hdl/sgim_pkg.sv */
// Shared types, constants and the microcode table of the spiral grid index map.
// Used by the channel interfaces, the sequencer, the datapath and the register block.
// Depends on nothing.
package sgim_pkg;

   // Largest grid side that the datapath handles; larger register values saturate.
   localparam int unsigned MAX_DIM = 256;
   localparam int unsigned DIM_W   = 9;
   localparam int unsigned VAL_W   = 17;
   localparam int unsigned K_W     = $clog2(MAX_DIM / 2);
   localparam int unsigned RING_W  = DIM_W + 2;
   localparam int unsigned STEP_W  = 5;

   // Configuration port geometry.
   localparam int unsigned PADDR_W = 3;
   localparam int unsigned PDATA_W = 32;

   // Register index, taken from paddr[2].
   localparam logic REG_GRID_COLS = 1'b0;
   localparam logic REG_GRID_ROWS = 1'b1;

   typedef logic [STEP_W-1:0] step_type;

   // Datapath operations selected by one control word.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_PT_RING,
      OP_PT_DIMS,
      OP_PT_BEFORE,
      OP_PT_OFFSET,
      OP_PT_NUMBER,
      OP_V_INIT,
      OP_V_WALK,
      OP_V_OFFSET,
      OP_V_SEG,
      OP_FOUND,
      OP_FAIL,
      OP_FINISH
   } op_type;

   // Jump conditions tested by the sequencer.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_REQ_VALUE,
      COND_PT_OUTSIDE,
      COND_V_OUTSIDE,
      COND_RING_MORE,
      COND_SEG_HIT,
      COND_OUT_FREE
   } cond_type;

   // The four sides of a ring, in numbering order.
   typedef enum logic [1:0] {
      SEG_LEFT,
      SEG_TOP,
      SEG_RIGHT,
      SEG_BOTTOM
   } seg_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      seg_type  seg;
      logic     last;
   } uword_type;

   typedef struct packed {
      logic req_value;
      logic pt_outside;
      logic v_outside;
      logic ring_more;
      logic seg_hit;
      logic out_free;
   } status_type;

   // Program addresses.
   localparam step_type STEP_BRANCH    = 5'd0;
   localparam step_type STEP_PT_CHECK  = 5'd1;
   localparam step_type STEP_PT_RING   = 5'd2;
   localparam step_type STEP_PT_DIMS   = 5'd3;
   localparam step_type STEP_PT_BEFORE = 5'd4;
   localparam step_type STEP_PT_OFFSET = 5'd5;
   localparam step_type STEP_PT_NUMBER = 5'd6;
   localparam step_type STEP_V_INIT    = 5'd7;
   localparam step_type STEP_V_CHECK   = 5'd8;
   localparam step_type STEP_V_WALK    = 5'd9;
   localparam step_type STEP_V_OFFSET  = 5'd10;
   localparam step_type STEP_V_LEFT    = 5'd11;
   localparam step_type STEP_V_TOP     = 5'd12;
   localparam step_type STEP_V_RIGHT   = 5'd13;
   localparam step_type STEP_V_BOTTOM  = 5'd14;
   localparam step_type STEP_FOUND     = 5'd15;
   localparam step_type STEP_FAIL      = 5'd16;
   localparam step_type STEP_FINISH    = 5'd17;

   localparam uword_type UWORD_IDLE = '{
      op: OP_NOP, cond: COND_NEVER, target: STEP_BRANCH, seg: SEG_LEFT, last: 1'b0
   };

   // Builds one control word.
   function automatic uword_type uword(input op_type op, input cond_type cond,
                                      input step_type target, input seg_type seg,
                                      input logic last);
      uword_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      w.seg    = seg;
      w.last   = last;
      return w;
   endfunction

   // The microprogram. A word jumps to its target when its condition holds and
   // otherwise falls through; the last word holds until its condition holds.
   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      unique case (step)
         STEP_BRANCH:    w = uword(OP_NOP, COND_REQ_VALUE, STEP_V_INIT, SEG_LEFT, 1'b0);
         STEP_PT_CHECK:  w = uword(OP_NOP, COND_PT_OUTSIDE, STEP_FAIL, SEG_LEFT, 1'b0);
         STEP_PT_RING:   w = uword(OP_PT_RING, COND_NEVER, STEP_BRANCH, SEG_LEFT, 1'b0);
         STEP_PT_DIMS:   w = uword(OP_PT_DIMS, COND_NEVER, STEP_BRANCH, SEG_LEFT, 1'b0);
         STEP_PT_BEFORE: w = uword(OP_PT_BEFORE, COND_NEVER, STEP_BRANCH, SEG_LEFT, 1'b0);
         STEP_PT_OFFSET: w = uword(OP_PT_OFFSET, COND_NEVER, STEP_BRANCH, SEG_LEFT, 1'b0);
         STEP_PT_NUMBER: w = uword(OP_PT_NUMBER, COND_ALWAYS, STEP_FINISH, SEG_LEFT, 1'b0);
         STEP_V_INIT:    w = uword(OP_V_INIT, COND_NEVER, STEP_BRANCH, SEG_LEFT, 1'b0);
         STEP_V_CHECK:   w = uword(OP_NOP, COND_V_OUTSIDE, STEP_FAIL, SEG_LEFT, 1'b0);
         STEP_V_WALK:    w = uword(OP_V_WALK, COND_RING_MORE, STEP_V_WALK, SEG_LEFT, 1'b0);
         STEP_V_OFFSET:  w = uword(OP_V_OFFSET, COND_NEVER, STEP_BRANCH, SEG_LEFT, 1'b0);
         STEP_V_LEFT:    w = uword(OP_V_SEG, COND_SEG_HIT, STEP_FOUND, SEG_LEFT, 1'b0);
         STEP_V_TOP:     w = uword(OP_V_SEG, COND_SEG_HIT, STEP_FOUND, SEG_TOP, 1'b0);
         STEP_V_RIGHT:   w = uword(OP_V_SEG, COND_SEG_HIT, STEP_FOUND, SEG_RIGHT, 1'b0);
         STEP_V_BOTTOM:  w = uword(OP_V_SEG, COND_SEG_HIT, STEP_FOUND, SEG_BOTTOM, 1'b0);
         STEP_FOUND:     w = uword(OP_FOUND, COND_ALWAYS, STEP_FINISH, SEG_LEFT, 1'b0);
         STEP_FAIL:      w = uword(OP_FAIL, COND_NEVER, STEP_BRANCH, SEG_LEFT, 1'b0);
         STEP_FINISH:    w = uword(OP_FINISH, COND_OUT_FREE, STEP_BRANCH, SEG_LEFT, 1'b1);
         default:        w = uword(OP_NOP, COND_ALWAYS, STEP_FAIL, SEG_LEFT, 1'b0);
      endcase
      return w;
   endfunction

   // Saturates a grid side register to the largest supported side.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
   endfunction

   function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                                input logic [DIM_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

/* hdl/sgim_req_if.sv */
// Request channel: valid/ready handshake carrying one query beat.
// Depends on sgim_pkg for the field widths.
interface sgim_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [sgim_pkg::DIM_W-1:0]    query_x;
   logic [sgim_pkg::DIM_W-1:0]    query_y;
   logic [sgim_pkg::VAL_W-1:0]    query_value;

   modport source (output valid, output req_type, output query_x, output query_y,
                   output query_value, input ready);
   modport sink (input valid, input req_type, input query_x, input query_y,
                 input query_value, output ready);
endinterface

/* hdl/sgim_rsp_if.sv */
// Response channel: valid/ready handshake carrying one result beat.
// Depends on sgim_pkg for the field widths.
interface sgim_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [sgim_pkg::VAL_W-1:0]    value_out;
   logic [sgim_pkg::DIM_W-1:0]    x_out;
   logic [sgim_pkg::DIM_W-1:0]    y_out;

   modport source (output valid, output found, output value_out, output x_out,
                   output y_out, input ready);
   modport sink (input valid, input found, input value_out, input x_out,
                 input y_out, output ready);
endinterface

/* hdl/sgim_csr.sv */
// Grid size registers behind an APB-style write/read port.
// Depends on sgim_pkg.
module sgim_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sgim_pkg::PADDR_W-1:0]    paddr,
   input  logic [sgim_pkg::PDATA_W-1:0]    pwdata,
   output logic [sgim_pkg::PDATA_W-1:0]    prdata,
   output logic                            pready,
   output logic [sgim_pkg::DIM_W-1:0]      grid_cols,
   output logic [sgim_pkg::DIM_W-1:0]      grid_rows
);

   logic [sgim_pkg::DIM_W-1:0] cols_ff, cols_in;
   logic [sgim_pkg::DIM_W-1:0] rows_ff, rows_in;
   logic                       wr_en;
   logic                       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   // Register write decode.
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (wr_en) begin
         unique case (reg_sel)
            sgim_pkg::REG_GRID_COLS: cols_in = pwdata[sgim_pkg::DIM_W-1:0];
            sgim_pkg::REG_GRID_ROWS: rows_in = pwdata[sgim_pkg::DIM_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= sgim_pkg::DIM_W'(1);
         rows_ff <= sgim_pkg::DIM_W'(1);
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_sel)
         sgim_pkg::REG_GRID_COLS: prdata = sgim_pkg::PDATA_W'(cols_ff);
         sgim_pkg::REG_GRID_ROWS: prdata = sgim_pkg::PDATA_W'(rows_ff);
      endcase
   end

   assign grid_cols = cols_ff;
   assign grid_rows = rows_ff;

endmodule

/* hdl/sgim_useq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on sgim_pkg for the control word, status flags and the program.
module sgim_useq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  sgim_pkg::status_type   status,
   output sgim_pkg::uword_type    ctrl,
   output logic                   busy
);

   logic                 busy_ff, busy_in;
   sgim_pkg::step_type   step_ff, step_in;
   sgim_pkg::uword_type  word;
   logic                 cond_true;

   assign word = sgim_pkg::ucode_rom(step_ff);

   // Condition select.
   always_comb begin
      unique case (word.cond)
         sgim_pkg::COND_NEVER:      cond_true = 1'b0;
         sgim_pkg::COND_ALWAYS:     cond_true = 1'b1;
         sgim_pkg::COND_REQ_VALUE:  cond_true = status.req_value;
         sgim_pkg::COND_PT_OUTSIDE: cond_true = status.pt_outside;
         sgim_pkg::COND_V_OUTSIDE:  cond_true = status.v_outside;
         sgim_pkg::COND_RING_MORE:  cond_true = status.ring_more;
         sgim_pkg::COND_SEG_HIT:    cond_true = status.seg_hit;
         sgim_pkg::COND_OUT_FREE:   cond_true = status.out_free;
      endcase
   end

   // Next step: start on an accepted beat, jump or fall through while busy,
   // and leave the program once the last word's condition holds.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (accept) begin
            busy_in = 1'b1;
            step_in = sgim_pkg::STEP_BRANCH;
         end
      end else if (word.last) begin
         if (cond_true) begin
            busy_in = 1'b0;
         end
      end else if (cond_true) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + sgim_pkg::step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= sgim_pkg::STEP_BRANCH;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ctrl = busy_ff ? word : sgim_pkg::UWORD_IDLE;
   assign busy = busy_ff;

endmodule

/* hdl/sgim_datapath.sv */
// Datapath of the spiral index map: query registers, ring walker, offset and
// point arithmetic, and the response register. Driven by sgim_useq control words.
// Depends on sgim_pkg.
module sgim_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          in_req_type,
   input  logic [sgim_pkg::DIM_W-1:0]    in_query_x,
   input  logic [sgim_pkg::DIM_W-1:0]    in_query_y,
   input  logic [sgim_pkg::VAL_W-1:0]    in_query_value,
   input  logic [sgim_pkg::DIM_W-1:0]    cfg_cols,
   input  logic [sgim_pkg::DIM_W-1:0]    cfg_rows,
   input  sgim_pkg::uword_type           ctrl,
   output sgim_pkg::status_type          status,
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic                          out_found,
   output logic [sgim_pkg::VAL_W-1:0]    out_value,
   output logic [sgim_pkg::DIM_W-1:0]    out_x,
   output logic [sgim_pkg::DIM_W-1:0]    out_y
);

   localparam int unsigned DW = sgim_pkg::DIM_W;
   localparam int unsigned VW = sgim_pkg::VAL_W;
   localparam int unsigned KW = sgim_pkg::K_W;
   localparam int unsigned RW = sgim_pkg::RING_W;

   // Working registers.
   logic          type_ff, type_in;
   logic [DW-1:0] cols_ff, cols_in, rows_ff, rows_in;
   logic [DW-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [VW-1:0] qv_ff, qv_in;
   logic [KW-1:0] k_ff, k_in;
   logic [DW-1:0] w_ff, w_in, h_ff, h_in;
   logic [VW-1:0] total_ff, total_in, before_ff, before_in, off_ff, off_in;
   logic          found_ff, found_in;
   logic [VW-1:0] num_ff, num_in;
   logic [DW-1:0] px_ff, px_in, py_ff, py_in;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic [DW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // Combinational terms.
   logic [2*DW-1:0] total_prod, wh_prod;
   logic [DW-1:0]   k_dim, two_k, lx, hx, ly, hy, k_pt_dim;
   logic [VW-1:0]   pt_off;
   logic [RW-1:0]   ring;
   logic [VW-1:0]   ring_end, qv_m1;
   logic [DW-1:0]   seg_len, off_dim, seg_px, seg_py;
   logic            out_free;

   assign total_prod = cols_ff * rows_ff;
   assign wh_prod    = w_ff * h_ff;
   assign k_dim      = DW'(k_ff);
   assign two_k      = DW'({k_ff, 1'b0});
   assign lx         = k_dim + DW'(1);
   assign ly         = lx;
   assign hx         = cols_ff - k_dim;
   assign hy         = rows_ff - k_dim;

   // Ring index of a point: its distance to the nearest edge.
   assign k_pt_dim = sgim_pkg::min_dim(
                        sgim_pkg::min_dim(qx_ff - DW'(1), qy_ff - DW'(1)),
                        sgim_pkg::min_dim(cols_ff - qx_ff, rows_ff - qy_ff));

   // Offset of a point along its ring, one side at a time.
   always_comb begin
      if (qx_ff == lx) begin
         pt_off = VW'(qy_ff - ly);
      end else if (qy_ff == hy) begin
         pt_off = VW'(h_ff) + VW'(qx_ff - lx - DW'(1));
      end else if (qx_ff == hx) begin
         pt_off = VW'(h_ff) + VW'(w_ff - DW'(1)) + VW'(hy - DW'(1) - qy_ff);
      end else begin
         pt_off = VW'(h_ff) + VW'(w_ff - DW'(1)) + VW'(h_ff - DW'(1))
                + VW'(hx - DW'(1) - qx_ff);
      end
   end

   // Cell count of the current ring; a one-row or one-column ring is walked once.
   always_comb begin
      if (w_ff >= DW'(2) && h_ff >= DW'(2)) begin
         ring = ((RW'(w_ff) + RW'(h_ff)) << 1) - RW'(4);
      end else if (w_ff == DW'(1)) begin
         ring = RW'(h_ff);
      end else if (h_ff == DW'(1)) begin
         ring = RW'(w_ff);
      end else begin
         ring = '0;
      end
   end

   assign qv_m1    = qv_ff - VW'(1);
   assign ring_end = before_ff + VW'(ring);
   assign off_dim  = off_ff[DW-1:0];

   // Side length and the point that an offset lands on, per side.
   always_comb begin
      unique case (ctrl.seg)
         sgim_pkg::SEG_LEFT: begin
            seg_len = h_ff;
            seg_px  = lx;
            seg_py  = ly + off_dim;
         end
         sgim_pkg::SEG_TOP: begin
            seg_len = w_ff - DW'(1);
            seg_px  = lx + DW'(1) + off_dim;
            seg_py  = hy;
         end
         sgim_pkg::SEG_RIGHT: begin
            seg_len = h_ff - DW'(1);
            seg_px  = hx;
            seg_py  = hy - DW'(1) - off_dim;
         end
         sgim_pkg::SEG_BOTTOM: begin
            seg_len = '0;
            seg_px  = hx - DW'(1) - off_dim;
            seg_py  = ly;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || out_ready;

   // Status flags for the sequencer's jumps.
   always_comb begin
      status.req_value  = type_ff;
      status.pt_outside = (qx_ff == '0) || (qy_ff == '0) || (qx_ff > cols_ff)
                          || (qy_ff > rows_ff);
      status.v_outside  = (qv_ff == '0) || (qv_ff > total_ff);
      status.ring_more  = (qv_m1 >= ring_end);
      status.seg_hit    = (ctrl.seg == sgim_pkg::SEG_BOTTOM) || (off_ff < VW'(seg_len));
      status.out_free   = out_free;
   end

   // Register updates selected by the control word.
   always_comb begin
      type_in   = type_ff;
      cols_in   = cols_ff;
      rows_in   = rows_ff;
      qx_in     = qx_ff;
      qy_in     = qy_ff;
      qv_in     = qv_ff;
      k_in      = k_ff;
      w_in      = w_ff;
      h_in      = h_ff;
      total_in  = total_ff;
      before_in = before_ff;
      off_in    = off_ff;
      found_in  = found_ff;
      num_in    = num_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;

      if (accept) begin
         type_in  = in_req_type;
         cols_in  = sgim_pkg::eff_dim(cfg_cols);
         rows_in  = sgim_pkg::eff_dim(cfg_rows);
         qx_in    = in_query_x;
         qy_in    = in_query_y;
         qv_in    = in_query_value;
         found_in = 1'b0;
         num_in   = '0;
         px_in    = '0;
         py_in    = '0;
      end else begin
         unique case (ctrl.op)
            sgim_pkg::OP_NOP: begin
            end
            sgim_pkg::OP_PT_RING: begin
               k_in = k_pt_dim[KW-1:0];
            end
            sgim_pkg::OP_PT_DIMS: begin
               w_in     = cols_ff - two_k;
               h_in     = rows_ff - two_k;
               total_in = total_prod[VW-1:0];
            end
            sgim_pkg::OP_PT_BEFORE: begin
               before_in = total_ff - wh_prod[VW-1:0];
            end
            sgim_pkg::OP_PT_OFFSET: begin
               off_in = pt_off;
            end
            sgim_pkg::OP_PT_NUMBER: begin
               num_in   = before_ff + off_ff + VW'(1);
               found_in = 1'b1;
            end
            sgim_pkg::OP_V_INIT: begin
               total_in  = total_prod[VW-1:0];
               k_in      = '0;
               w_in      = cols_ff;
               h_in      = rows_ff;
               before_in = '0;
            end
            sgim_pkg::OP_V_WALK: begin
               if (status.ring_more) begin
                  before_in = ring_end;
                  k_in      = k_ff + KW'(1);
                  w_in      = w_ff - DW'(2);
                  h_in      = h_ff - DW'(2);
               end
            end
            sgim_pkg::OP_V_OFFSET: begin
               off_in = qv_m1 - before_ff;
            end
            sgim_pkg::OP_V_SEG: begin
               if (status.seg_hit) begin
                  px_in = seg_px;
                  py_in = seg_py;
               end else begin
                  off_in = off_ff - VW'(seg_len);
               end
            end
            sgim_pkg::OP_FOUND: begin
               found_in = 1'b1;
            end
            sgim_pkg::OP_FAIL: begin
               found_in = 1'b0;
               num_in   = '0;
               px_in    = '0;
               py_in    = '0;
            end
            sgim_pkg::OP_FINISH: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = found_ff;
                  rsp_value_in = num_ff;
                  rsp_x_in     = px_ff;
                  rsp_y_in     = py_ff;
               end
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      cols_ff   <= cols_in;
      rows_ff   <= rows_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      qv_ff     <= qv_in;
      k_ff      <= k_in;
      w_ff      <= w_in;
      h_ff      <= h_in;
      total_ff  <= total_in;
      before_ff <= before_in;
      off_ff    <= off_in;
      found_ff  <= found_in;
      num_ff    <= num_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
   end

   // Response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_found = rsp_found_ff;
   assign out_value = rsp_value_ff;
   assign out_x     = rsp_x_ff;
   assign out_y     = rsp_y_ff;

endmodule

/* hdl/spiral_grid_index_map.sv */
// Spiral grid index map. A grid of grid_cols by grid_rows cells is numbered
// 1 to cols*rows clockwise from (1,1): up the left column, along the top row,
// down the right column, back along the bottom row, then one ring inward.
// Request beats on req_chan ask either the number at (query_x, query_y)
// (req_type 0) or the cell that holds query_value (req_type 1). Each request
// yields one beat on rsp_chan; found is 0 and all other fields 0 when the
// query falls outside the grid. Register values above 256 are used as 256.
// The grid size registers sit at byte addresses 0 (columns) and 4 (rows) of
// the APB port and must be written only while the block is idle.
// One request is worked at a time by a microcoded sequencer over a shared
// datapath, one control word per cycle. A point query runs the branch, bounds
// check, ring, sides, prior-count, offset, number and finish words; a value
// query runs branch, init and bounds check, the ring walker, which repeats per
// outer ring skipped (at most 127), offset, the side words from left to the
// side of its ring (0 to 3), found and finish. Outside the grid both go from
// the bounds check to fail and finish. req_chan.ready rises at the edge that
// loads the response; no request is taken before then. The response
// register holds one result: when the receiver stalls, the next request may
// still be accepted and worked, and waits at its final step until the
// register frees. Synchronous reset clears the sequencer and the response valid, and sets both grid sides to 1.
module spiral_grid_index_map (
   input  logic                            clock,
   input  logic                            reset,
   sgim_req_if.sink                        req_chan,
   sgim_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sgim_pkg::PADDR_W-1:0]    paddr,
   input  logic [sgim_pkg::PDATA_W-1:0]    pwdata,
   output logic [sgim_pkg::PDATA_W-1:0]    prdata,
   output logic                            pready
);

   logic [sgim_pkg::DIM_W-1:0] grid_cols;
   logic [sgim_pkg::DIM_W-1:0] grid_rows;
   sgim_pkg::uword_type        ctrl;
   sgim_pkg::status_type       status;
   logic                       busy;
   logic                       accept;

   // A new request is taken whenever the sequencer is idle.
   assign req_chan.ready = !busy;
   assign accept         = req_chan.valid && !busy;

   sgim_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .grid_cols (grid_cols),
      .grid_rows (grid_rows)
   );

   sgim_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   sgim_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .in_req_type    (req_chan.req_type),
      .in_query_x     (req_chan.query_x),
      .in_query_y     (req_chan.query_y),
      .in_query_value (req_chan.query_value),
      .cfg_cols       (grid_cols),
      .cfg_rows       (grid_rows),
      .ctrl           (ctrl),
      .status         (status),
      .out_ready      (rsp_chan.ready),
      .out_valid      (rsp_chan.valid),
      .out_found      (rsp_chan.found),
      .out_value      (rsp_chan.value_out),
      .out_x          (rsp_chan.x_out),
      .out_y          (rsp_chan.y_out)
   );

endmodule

/* hdl/sgim_checker.sv */
// Port-level checks of the spiral grid index map, attached by bind.
// Depends on sgim_pkg and on spiral_grid_index_map.
module sgim_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [sgim_pkg::VAL_W-1:0]    rsp_value_out,
   input logic [sgim_pkg::DIM_W-1:0]    rsp_x_out,
   input logic [sgim_pkg::DIM_W-1:0]    rsp_y_out
);

   // Reset empties the response register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_value_out) && $stable(rsp_x_out) && $stable(rsp_y_out))
      else $error("stalled response beat changed");

   // A miss carries all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_value_out == '0 && rsp_x_out == '0
         && rsp_y_out == '0)
      else $error("miss with nonzero fields");

   // A hit carries either a number or a point, never both or neither.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
         (rsp_value_out != '0 && rsp_x_out == '0 && rsp_y_out == '0)
         || (rsp_value_out == '0 && rsp_x_out != '0 && rsp_y_out != '0))
      else $error("hit with inconsistent fields");

   // One request is worked at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind spiral_grid_index_map sgim_checker u_sgim_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_found     (rsp_chan.found),
   .rsp_value_out (rsp_chan.value_out),
   .rsp_x_out     (rsp_chan.x_out),
   .rsp_y_out     (rsp_chan.y_out)
);

/* bench/spiral_grid_index_map_tb.sv */
// Self-checking bench for the spiral grid index map: directed table, then random phases.
// Expected answers come from the directed table or a ring-by-ring lookup model held here, compared beat by beat.
// Depends on sgim_pkg, sgim_req_if, sgim_rsp_if and the spiral_grid_index_map RTL.
module spiral_grid_index_map_tb;

   localparam int unsigned DIM_W   = sgim_pkg::DIM_W;
   localparam int unsigned VAL_W   = sgim_pkg::VAL_W;
   localparam int unsigned MAX_DIM = sgim_pkg::MAX_DIM;
   localparam int unsigned PADDR_W = sgim_pkg::PADDR_W;
   localparam int unsigned PDATA_W = sgim_pkg::PDATA_W;

   localparam int unsigned CLOCK_PERIOD    = 8;
   localparam int unsigned RESET_CYCLES    = 10;
   localparam int unsigned LIMIT_CYCLES    = 600000;
   localparam int unsigned DRAIN_CYCLES    = 16;
   localparam int unsigned LONG_HOLD       = 400;
   localparam int unsigned PHASE_COUNT     = 16;
   localparam int unsigned ITEMS_PER_PHASE = 40;
   localparam int unsigned DIRECTED_COUNT  = 25;

   // Request kinds and table markers.
   localparam logic POINT_QUERY = 1'b0;
   localparam logic VALUE_QUERY = 1'b1;
   localparam logic TYPED       = 1'b1;
   localparam logic PREDICTED   = 1'b0;
   localparam logic DO_WRITE    = 1'b1;
   localparam logic DO_READ     = 1'b0;

   typedef struct packed {
      logic             req_type;
      logic [DIM_W-1:0] query_x;
      logic [DIM_W-1:0] query_y;
      logic [VAL_W-1:0] query_value;
   } spiral_query_type;

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] value_out;
      logic [DIM_W-1:0] x_out;
      logic [DIM_W-1:0] y_out;
   } spiral_answer_type;

   typedef struct packed {
      logic [DIM_W-1:0]  cols;
      logic [DIM_W-1:0]  rows;
      spiral_query_type  q;
      logic              typed;
      spiral_answer_type a;
   } directed_row_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   sgim_req_if req_bus ();
   sgim_rsp_if rsp_bus ();

   spiral_grid_index_map uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Grid sides as last written, raw register values.
   logic [DIM_W-1:0] grid_cols_setting;
   logic [DIM_W-1:0] grid_rows_setting;

   spiral_answer_type expected_answers[$];
   int unsigned mismatch_count;
   bit calm_phase;
   bit hold_off_request;

   // Directed cases: reset grid, full-size grid, saturated sides, empty grid,
   // single column and single row, and grids whose inner ring degenerates.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{9'd1, 9'd1, '{POINT_QUERY, 9'd1, 9'd1, 17'd0}, TYPED, '{1'b1, 17'd1, 9'd0, 9'd0}},
      '{9'd1, 9'd1, '{VALUE_QUERY, 9'h1FF, 9'h1FF, 17'd1}, TYPED, '{1'b1, 17'd0, 9'd1, 9'd1}},
      '{9'd1, 9'd1, '{POINT_QUERY, 9'd0, 9'd0, 17'h1FFFF}, TYPED, '0},
      '{9'd1, 9'd1, '{VALUE_QUERY, 9'd1, 9'd1, 17'd0}, TYPED, '0},
      '{9'd1, 9'd1, '{POINT_QUERY, 9'd2, 9'd1, 17'd0}, TYPED, '0},
      '{9'd256, 9'd256, '{POINT_QUERY, 9'd1, 9'd1, 17'h1FFFF}, TYPED, '{1'b1, 17'd1, 9'd0, 9'd0}},
      '{9'd256, 9'd256, '{POINT_QUERY, 9'd1, 9'd256, 17'd0}, TYPED,
        '{1'b1, 17'd256, 9'd0, 9'd0}},
      '{9'd256, 9'd256, '{POINT_QUERY, 9'd256, 9'd256, 17'd0}, PREDICTED, '0},
      '{9'd256, 9'd256, '{POINT_QUERY, 9'h1FF, 9'h1FF, 17'd0}, TYPED, '0},
      '{9'd256, 9'd256, '{VALUE_QUERY, 9'd0, 9'd0, 17'd65536}, PREDICTED, '0},
      '{9'd256, 9'd256, '{VALUE_QUERY, 9'd0, 9'd0, 17'd65537}, TYPED, '0},
      '{9'd256, 9'd256, '{VALUE_QUERY, 9'h1FF, 9'h1FF, 17'h1FFFF}, TYPED, '0},
      '{9'd256, 9'd256, '{VALUE_QUERY, 9'd0, 9'd0, 17'd1}, TYPED, '{1'b1, 17'd0, 9'd1, 9'd1}},
      '{9'd511, 9'd300, '{POINT_QUERY, 9'd256, 9'd256, 17'd0}, PREDICTED, '0},
      '{9'd511, 9'd300, '{POINT_QUERY, 9'd257, 9'd1, 17'd0}, TYPED, '0},
      '{9'd511, 9'd300, '{VALUE_QUERY, 9'd0, 9'd0, 17'd65536}, PREDICTED, '0},
      '{9'd0, 9'd5, '{POINT_QUERY, 9'd1, 9'd1, 17'd0}, TYPED, '0},
      '{9'd0, 9'd5, '{VALUE_QUERY, 9'd0, 9'd0, 17'd1}, TYPED, '0},
      '{9'd1, 9'd7, '{VALUE_QUERY, 9'd0, 9'd0, 17'd7}, TYPED, '{1'b1, 17'd0, 9'd1, 9'd7}},
      '{9'd1, 9'd7, '{POINT_QUERY, 9'd1, 9'd4, 17'd0}, TYPED, '{1'b1, 17'd4, 9'd0, 9'd0}},
      '{9'd9, 9'd1, '{VALUE_QUERY, 9'd0, 9'd0, 17'd9}, PREDICTED, '0},
      '{9'd9, 9'd1, '{POINT_QUERY, 9'd5, 9'd1, 17'd0}, PREDICTED, '0},
      '{9'd5, 9'd3, '{VALUE_QUERY, 9'd0, 9'd0, 17'd15}, PREDICTED, '0},
      '{9'd5, 9'd3, '{POINT_QUERY, 9'd3, 9'd2, 17'd0}, PREDICTED, '0},
      '{9'd6, 9'd4, '{VALUE_QUERY, 9'd0, 9'd0, 17'd24}, PREDICTED, '0}
   };

   // Side of the grid as the block uses it: values above the limit saturate.
   function automatic int unsigned side_in_use(input logic [DIM_W-1:0] side_reg);
      return (32'(side_reg) > MAX_DIM) ? MAX_DIM : 32'(side_reg);
   endfunction

   // Spiral lookup: number at a point, or the point holding a number, ring by ring.
   function automatic spiral_answer_type spiral_lookup(input logic [DIM_W-1:0] cols_reg,
                                                       input logic [DIM_W-1:0] rows_reg,
                                                       input spiral_query_type q);
      int unsigned cols, rows, x, y, v, k, w, h, prior, offs, ring;
      bit located;
      spiral_answer_type a;
      cols = side_in_use(cols_reg);
      rows = side_in_use(rows_reg);
      a = '0;
      if (q.req_type == POINT_QUERY) begin
         x = 32'(q.query_x);
         y = 32'(q.query_y);
         if (x >= 1 && y >= 1 && x <= cols && y <= rows) begin
            // The ring index is the distance to the nearest edge.
            k = (x < y) ? x - 1 : y - 1;
            if (cols - x < k) k = cols - x;
            if (rows - y < k) k = rows - y;
            w = cols - 2 * k;
            h = rows - 2 * k;
            prior = cols * rows - w * h;
            if (x == 1 + k)
               offs = y - (1 + k);
            else if (y == rows - k)
               offs = h + (x - (1 + k) - 1);
            else if (x == cols - k)
               offs = h + (w - 1) + (rows - k - 1 - y);
            else
               offs = h + (w - 1) + (h - 1) + (cols - k - 1 - x);
            a.found = 1'b1;
            a.value_out = VAL_W'(prior + offs + 1);
         end
      end else begin
         v = 32'(q.query_value);
         if (v >= 1 && v <= cols * rows) begin
            // Skip whole rings; a one-row or one-column ring counts its cells once.
            k = 0;
            w = cols;
            h = rows;
            prior = 0;
            located = 1'b0;
            while (!located) begin
               ring = (w >= 2 && h >= 2) ? (w * h - (w - 2) * (h - 2)) : (w * h);
               if (v - 1 < prior + ring) begin
                  located = 1'b1;
               end else begin
                  prior += ring;
                  k++;
                  w -= 2;
                  h -= 2;
               end
            end
            // Walk the sides in numbering order: left, top, right, bottom.
            offs = v - 1 - prior;
            if (offs < h) begin
               x = 1 + k;
               y = 1 + k + offs;
            end else begin
               offs -= h;
               if (offs < w - 1) begin
                  x = 2 + k + offs;
                  y = rows - k;
               end else begin
                  offs -= w - 1;
                  if (offs < h - 1) begin
                     x = cols - k;
                     y = rows - k - 1 - offs;
                  end else begin
                     offs -= h - 1;
                     x = cols - k - 1 - offs;
                     y = 1 + k;
                  end
               end
            end
            a.found = 1'b1;
            a.x_out = DIM_W'(x);
            a.y_out = DIM_W'(y);
         end
      end
      return a;
   endfunction

   // Random request: mostly inside the grid, the rest raw bits.
   function automatic spiral_query_type random_query(input logic [DIM_W-1:0] cols_reg,
                                                     input logic [DIM_W-1:0] rows_reg);
      spiral_query_type q;
      int unsigned cols, rows;
      cols = side_in_use(cols_reg);
      rows = side_in_use(rows_reg);
      q.req_type = 1'($urandom_range(0, 1));
      q.query_x = DIM_W'($urandom());
      q.query_y = DIM_W'($urandom());
      q.query_value = VAL_W'($urandom());
      if (cols != 0 && rows != 0 && $urandom_range(0, 99) < 85) begin
         if (q.req_type == POINT_QUERY) begin
            q.query_x = DIM_W'($urandom_range(1, cols));
            q.query_y = DIM_W'($urandom_range(1, rows));
         end else begin
            q.query_value = VAL_W'($urandom_range(1, cols * rows));
         end
      end
      return q;
   endfunction

   // Grid side for a random phase: mostly small, sometimes empty, full or saturated.
   function automatic logic [DIM_W-1:0] random_side();
      unique case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return DIM_W'(MAX_DIM);
         end
         2: begin
            return DIM_W'($urandom_range(MAX_DIM + 1, 511));
         end
         3: begin
            return DIM_W'(1);
         end
         default: begin
            return DIM_W'($urandom_range(2, 16));
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // One APB transfer: setup cycle, then access cycle until pready.
   task automatic apb_access(input logic write_en, input logic index,
                             input logic [DIM_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write_en;
      paddr <= {index, 2'b00};
      pwdata <= {(PDATA_W - DIM_W)'($urandom()), wdata};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Write both grid sides, then read them back.
   task automatic program_grid(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
      logic [PDATA_W-1:0] rdata;
      apb_access(DO_WRITE, sgim_pkg::REG_GRID_COLS, cols, rdata);
      apb_access(DO_WRITE, sgim_pkg::REG_GRID_ROWS, rows, rdata);
      grid_cols_setting = cols;
      grid_rows_setting = rows;
      apb_access(DO_READ, sgim_pkg::REG_GRID_COLS, '0, rdata);
      if (rdata[DIM_W-1:0] !== cols)
         report_mismatch("grid_cols readback", 32'(rdata[DIM_W-1:0]), 32'(cols));
      apb_access(DO_READ, sgim_pkg::REG_GRID_ROWS, '0, rdata);
      if (rdata[DIM_W-1:0] !== rows)
         report_mismatch("grid_rows readback", 32'(rdata[DIM_W-1:0]), 32'(rows));
   endtask

   // Offer one request beat after a random gap, none in a calm phase; record its answer once accepted.
   task automatic send_query(input spiral_query_type q, input spiral_answer_type answer);
      int unsigned gap;
      gap = calm_phase ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= q.req_type;
      req_bus.query_x <= q.query_x;
      req_bus.query_y <= q.query_y;
      req_bus.query_value <= q.query_value;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      expected_answers.push_back(answer);
   endtask

   // Drop valid and wait until every answer has come back and the block is quiet.
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: random hold-off before each beat (none in a calm phase), one long hold-off on request.
   initial begin
      int unsigned hold;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_request) begin
            hold = LONG_HOLD;
            hold_off_request = 1'b0;
         end else begin
            hold = calm_phase ? 0 : $urandom_range(0, 3);
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // Compare each response beat with the oldest outstanding answer.
   always @(posedge clock) begin
      spiral_answer_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected response beat, value_out",
                            32'(rsp_bus.value_out), 0);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_bus.found !== want.found)
               report_mismatch("found", 32'(rsp_bus.found), 32'(want.found));
            if (rsp_bus.value_out !== want.value_out)
               report_mismatch("value_out", 32'(rsp_bus.value_out), 32'(want.value_out));
            if (rsp_bus.x_out !== want.x_out)
               report_mismatch("x_out", 32'(rsp_bus.x_out), 32'(want.x_out));
            if (rsp_bus.y_out !== want.y_out)
               report_mismatch("y_out", 32'(rsp_bus.y_out), 32'(want.y_out));
         end
      end
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin
      directed_row_type row;
      spiral_query_type q;
      int unsigned phase, n;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.req_type = POINT_QUERY;
      req_bus.query_x = '0;
      req_bus.query_y = '0;
      req_bus.query_value = '0;
      rsp_bus.ready = 1'b0;
      grid_cols_setting = DIM_W'(1);
      grid_rows_setting = DIM_W'(1);
      mismatch_count = 0;
      calm_phase = 1'b0;
      hold_off_request = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table; the grid is reprogrammed whenever a row asks for a new one.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_rows[i];
         if (row.cols != grid_cols_setting || row.rows != grid_rows_setting) begin
            settle_block();
            program_grid(row.cols, row.rows);
         end
         send_query(row.q, row.typed ? row.a
                                     : spiral_lookup(grid_cols_setting, grid_rows_setting, row.q));
      end

      // Random phases, each with its own grid; some without idling, one with a
      // long receiver hold-off and one with a sender pause until the block drains.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_block();
         program_grid(random_side(), random_side());
         calm_phase = (phase % 4 == 2);
         if (phase == 3)
            hold_off_request = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 5 && n == ITEMS_PER_PHASE / 2)
               settle_block();
            q = random_query(grid_cols_setting, grid_rows_setting);
            send_query(q, spiral_lookup(grid_cols_setting, grid_rows_setting, q));
         end
      end
      settle_block();

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
